// ----- rtl/pil_pkg.sv -----
// Shared types, operation codes and status codes for the positional insert list.
package pil_pkg;

	localparam int unsigned DEPTH_DEF = 16;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DEL_HEAD = 2'd1;
	localparam logic [1:0] CMD_DEL_TAIL = 2'd2;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic       load;
		logic       ins;
		logic       del_head;
		logic       del_tail;
		logic [1:0] status;
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} dp_stat_t;

endpackage

// ----- rtl/positional_insert_list_core.sv -----
// Top level of the positional insert list: bounded ordered list of signed words.
//
//   channel | valid     | stall     | payload
//   input   | in_valid  | in_stall  | cmd, value, position
//   output  | out_valid | out_stall | status, entry_count, removed_value, removed_valid
//
// All cells shift in parallel in the datapath and the result lands in a single
// output register.
// A new word is taken while the output register is empty or being drained.
// Reset clears the count and the output valid; cell contents are not reset.
// A stalled result holds in the output register and stalls the input.
module positional_insert_list_core #(
	parameter int unsigned DEPTH = pil_pkg::DEPTH_DEF,
	parameter int unsigned CW = $clog2(DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic signed [31:0] value,
	input  logic [7:0]         position,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [CW-1:0]      entry_count,
	output logic signed [31:0] removed_value,
	output logic               removed_valid
);
	import pil_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t stat;

	pil_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.dp_cmd    (dp_cmd)
	);

	pil_datapath #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.dp_cmd        (dp_cmd),
		.stat          (stat),
		.value         (value),
		.position      (position),
		.status        (status),
		.entry_count   (entry_count),
		.removed_value (removed_value),
		.removed_valid (removed_valid)
	);

endmodule

// ----- rtl/pil_ctrl.sv -----
// Controller: handshake state machine and operation decode.
module pil_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        cmd,
	output logic              out_valid,
	input  logic              out_stall,
	input  pil_pkg::dp_stat_t stat,
	output pil_pkg::dp_cmd_t  dp_cmd
);
	import pil_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_HOLD = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;

	assign out_valid = (state_q == S_HOLD);
	assign in_stall = out_valid && out_stall;
	assign accept = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		if (accept) begin
			state_d = S_HOLD;
		end else if (out_valid && !out_stall) begin
			state_d = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		dp_cmd = '0;
		dp_cmd.load = accept;
		dp_cmd.status = STAT_OK;
		unique case (cmd)
			CMD_INSERT: begin
				if (stat.full) begin
					dp_cmd.status = STAT_FULL;
				end else begin
					dp_cmd.ins = accept;
				end
			end
			CMD_DEL_HEAD: begin
				if (stat.empty) begin
					dp_cmd.status = STAT_EMPTY;
				end else begin
					dp_cmd.del_head = accept;
				end
			end
			CMD_DEL_TAIL: begin
				if (stat.empty) begin
					dp_cmd.status = STAT_EMPTY;
				end else begin
					dp_cmd.del_tail = accept;
				end
			end
			default: begin
				dp_cmd.status = STAT_OK;
			end
		endcase
	end

endmodule

// ----- rtl/pil_datapath.sv -----
// Datapath: entry cells with parallel shift, count register and result register.
module pil_datapath #(
	parameter int unsigned DEPTH = pil_pkg::DEPTH_DEF,
	parameter int unsigned CW = $clog2(DEPTH + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pil_pkg::dp_cmd_t        dp_cmd,
	output pil_pkg::dp_stat_t       stat,
	input  logic signed [31:0]      value,
	input  logic [7:0]              position,
	output logic [1:0]              status,
	output logic [CW-1:0]           entry_count,
	output logic signed [31:0]      removed_value,
	output logic                    removed_valid
);
	import pil_pkg::*;

	localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned PW = (CW > 8) ? CW : 8;

	logic signed [31:0] cell_q [DEPTH];
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_d;
	logic [CW-1:0]      idx;
	logic [PW-1:0]      pos_x;
	logic [PW-1:0]      cnt_x;
	logic [CW-1:0]      tail_m1;
	logic signed [31:0] rem_d;

	logic [1:0]         status_q;
	logic [CW-1:0]      ecount_q;
	logic signed [31:0] rem_q;
	logic               rvalid_q;

	assign stat.empty = (count_q == '0);
	assign stat.full = (count_q == CW'(DEPTH));

	assign pos_x = PW'(position);
	assign cnt_x = PW'(count_q);
	assign idx = (pos_x < cnt_x) ? CW'(pos_x) : count_q;
	assign tail_m1 = count_q - CW'(1);

	always_comb begin
		count_d = count_q;
		rem_d = '0;
		if (dp_cmd.ins) begin
			count_d = count_q + CW'(1);
		end else if (dp_cmd.del_head) begin
			count_d = tail_m1;
			rem_d = cell_q[0];
		end else if (dp_cmd.del_tail) begin
			count_d = tail_m1;
			rem_d = cell_q[tail_m1[IW-1:0]];
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (dp_cmd.ins) begin
				if (CW'(i) == idx) begin
					cell_q[i] <= value;
				end else if (CW'(i) > idx) begin
					if (i > 0) begin
						cell_q[i] <= cell_q[(i > 0) ? i - 1 : 0];
					end
				end
			end else if (dp_cmd.del_head) begin
				if (i + 1 < DEPTH) begin
					cell_q[i] <= cell_q[(i + 1 < DEPTH) ? i + 1 : i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			status_q <= dp_cmd.status;
			ecount_q <= count_d;
			rem_q <= rem_d;
			rvalid_q <= dp_cmd.del_head || dp_cmd.del_tail;
		end
	end

	assign status = status_q;
	assign entry_count = ecount_q;
	assign removed_value = rem_q;
	assign removed_valid = rvalid_q;

endmodule
